/* design/feistel_block_cipher_defines.svh */
// ----------------------------------------------------------------------------
// Feistel block cipher assertion macros
// Concurrent check helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FEISTEL_BLOCK_CIPHER_DEFINES_SVH
`define FEISTEL_BLOCK_CIPHER_DEFINES_SVH

`ifndef SYNTH
// Check that a condition holds at every clock edge outside reset
`define FBC_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("assertion failed");
// Check that a condition in one cycle implies another in the next cycle
`define FBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FBC_ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define FBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* design/fbc_pkg.sv */
// ----------------------------------------------------------------------------
// Feistel block cipher package
// Shared constants, types and the round function.
// ----------------------------------------------------------------------------
package fbc_pkg;

  localparam int unsigned BLOCK_W    = 64;
  localparam int unsigned HALF_W     = 32;
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned RCNT_W     = 6;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned MIN_ROUNDS = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_CIPHER_KEY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_COUNT = 1'b1;

  // Payload that travels down the round pipeline
  typedef struct packed {
    logic               op;
    logic [BLOCK_W-1:0] blk;
  } fbc_item_t;

  // F(L,K): rotl(L,9) xor not(xor of the 16 byte products of rotr(K,11) and L)
  function automatic logic [HALF_W-1:0] round_fn(input logic [HALF_W-1:0] l,
                                                 input logic [HALF_W-1:0] k);
    logic [HALF_W-1:0] kr;
    logic [15:0]       p;
    kr = {k[10:0], k[31:11]};
    p  = '0;
    for (int a = 0; a < 4; a++) begin
      for (int b = 0; b < 4; b++) begin
        p = p ^ (16'(kr[8*a +: 8]) * 16'(l[8*b +: 8]));
      end
    end
    return {l[22:0], l[31:23]} ^ ~{16'h0000, p};
  endfunction

endpackage

/* design/fbc_round.sv */
// ----------------------------------------------------------------------------
// Feistel round stage
// One registered round; encrypt and decrypt round keys are fixed rotations.
// ----------------------------------------------------------------------------
module fbc_round #(
  parameter int unsigned STAGE      = 0,
  parameter int unsigned MAX_ROUNDS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         valid_i,
  input  fbc_pkg::fbc_item_t           item_i,
  input  logic [fbc_pkg::KEY_W-1:0]    key_i,
  input  logic [fbc_pkg::RCNT_W-1:0]   round_count_i,
  output logic                         valid_o,
  output fbc_pkg::fbc_item_t           item_o
);

  localparam int unsigned ENC_ROT = (3 * STAGE) % 64;
  localparam int unsigned DEC_ROT = (3 * (MAX_ROUNDS - 1 - STAGE)) % 64;

  logic [fbc_pkg::HALF_W-1:0] enc_key, dec_key, rkey;
  logic [fbc_pkg::HALF_W-1:0] left, right, f_in, f_out;
  logic                       enc_act, dec_act, active;
  logic                       valid_q;
  fbc_pkg::fbc_item_t         item_d, item_q;

  // Pick the round key: encrypt rounds run from the front, decrypt from the back
  assign enc_key = fbc_pkg::HALF_W'({key_i, key_i} >> ENC_ROT);
  assign dec_key = fbc_pkg::HALF_W'({key_i, key_i} >> DEC_ROT);
  assign rkey    = item_i.op ? dec_key : enc_key;

  assign enc_act = 7'(STAGE) < {1'b0, round_count_i};
  assign dec_act = (7'(STAGE) + {1'b0, round_count_i}) >= 7'(MAX_ROUNDS);
  assign active  = item_i.op ? dec_act : enc_act;

  // Apply one round, or pass the block through when the stage is idle
  assign left  = item_i.blk[63:32];
  assign right = item_i.blk[31:0];
  assign f_in  = item_i.op ? right : left;
  assign f_out = fbc_pkg::round_fn(f_in, rkey);

  always_comb begin
    item_d.op = item_i.op;
    if (!active) begin
      item_d.blk = item_i.blk;
    end else if (item_i.op) begin
      item_d.blk = {right, left ^ f_out};
    end else begin
      item_d.blk = {right ^ f_out, left};
    end
  end

  // Hold on stall, advance otherwise
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* design/feistel_block_cipher.sv */
// A request is registered in every round stage, in order, on its way to the result.
// Throughput: one block per cycle while the result is not stalled; one register stage per Feistel round.
// A stalled result holds the whole round pipeline until it is taken.
// Reset clears all stage valid bits, cipher_key to 0 and round_count to 8.
// ----------------------------------------------------------------------------
// Feistel block cipher
// 64-bit Feistel encrypt/decrypt, fully unrolled round pipeline.
// ----------------------------------------------------------------------------
`include "feistel_block_cipher_defines.svh"

module feistel_block_cipher #(
  parameter int unsigned MAX_ROUNDS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fbc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fbc_pkg::KEY_W-1:0]      cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           operation_i,
  input  logic [fbc_pkg::BLOCK_W-1:0]    block_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [fbc_pkg::BLOCK_W-1:0]    block_out_o
);

  logic [fbc_pkg::KEY_W-1:0]  cipher_key_q, cipher_key_d;
  logic [fbc_pkg::RCNT_W-1:0] round_count_q, round_count_d;
  logic [fbc_pkg::RCNT_W-1:0] rc_wr;
  logic                       adv;

  logic                       stage_valid [0:MAX_ROUNDS];
  fbc_pkg::fbc_item_t         stage_item  [0:MAX_ROUNDS];

  // Clamp round count writes into the supported range
  assign rc_wr = cfg_wdata_i[fbc_pkg::RCNT_W-1:0];

  always_comb begin
    cipher_key_d  = cipher_key_q;
    round_count_d = round_count_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        fbc_pkg::CFG_CIPHER_KEY: begin
          cipher_key_d = cfg_wdata_i;
        end
        fbc_pkg::CFG_ROUND_COUNT: begin
          if ({1'b0, rc_wr} > 7'(MAX_ROUNDS)) begin
            round_count_d = fbc_pkg::RCNT_W'(MAX_ROUNDS);
          end else if (rc_wr < fbc_pkg::RCNT_W'(fbc_pkg::MIN_ROUNDS)) begin
            round_count_d = fbc_pkg::RCNT_W'(fbc_pkg::MIN_ROUNDS);
          end else begin
            round_count_d = rc_wr;
          end
        end
        default: begin
          cipher_key_d = cipher_key_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cipher_key_q  <= '0;
      round_count_q <= fbc_pkg::RCNT_W'(fbc_pkg::MIN_ROUNDS);
    end else begin
      cipher_key_q  <= cipher_key_d;
      round_count_q <= round_count_d;
    end
  end

  // Advance the pipeline unless the finished result is stalled
  assign adv        = !(stage_valid[MAX_ROUNDS] && out_stall_i);
  assign in_stall_o = !adv;

  assign stage_valid[0]    = in_valid_i;
  assign stage_item[0].op  = operation_i;
  assign stage_item[0].blk = block_in_i;

  for (genvar s = 0; s < MAX_ROUNDS; s++) begin : g_round
    fbc_round #(
      .STAGE      (s),
      .MAX_ROUNDS (MAX_ROUNDS)
    ) u_round (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .adv_i         (adv),
      .valid_i       (stage_valid[s]),
      .item_i        (stage_item[s]),
      .key_i         (cipher_key_q),
      .round_count_i (round_count_q),
      .valid_o       (stage_valid[s+1]),
      .item_o        (stage_item[s+1])
    );
  end

  assign out_valid_o = stage_valid[MAX_ROUNDS];
  assign block_out_o = stage_item[MAX_ROUNDS].blk;

  // Checks
  `FBC_ASSERT_ALWAYS(a_rc_range, clk_i, rst_ni, (round_count_q >= fbc_pkg::RCNT_W'(fbc_pkg::MIN_ROUNDS)) && ({1'b0, round_count_q} <= 7'(MAX_ROUNDS)))
  `FBC_ASSERT_ALWAYS(a_stall_needs_result, clk_i, rst_ni, !in_stall_o || (out_valid_o && out_stall_i))
  `FBC_ASSERT_NEXT(a_last_stage_moves, clk_i, rst_ni, adv && stage_valid[MAX_ROUNDS-1], out_valid_o)
  `FBC_ASSERT_NEXT(a_result_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(block_out_o))

endmodule

/* sim/fbc_block_checker.sv */
// ----------------------------------------------------------------------------
// Feistel block cipher result checker
// Tracks the key and round count from the register port, predicts the
// enciphered or deciphered block for every accepted request and compares it
// with each accepted result in order.
// ----------------------------------------------------------------------------
module fbc_block_checker #(
  parameter int unsigned MAX_ROUNDS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fbc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fbc_pkg::KEY_W-1:0]      cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic                           operation_i,
  input  logic [fbc_pkg::BLOCK_W-1:0]    block_in_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [fbc_pkg::BLOCK_W-1:0]    block_out_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o,
  output int unsigned                    encrypt_count_o,
  output int unsigned                    decrypt_count_o
);

  localparam int unsigned MAX_REPORTS = 10;

  logic [fbc_pkg::KEY_W-1:0]   key_q;
  logic [fbc_pkg::RCNT_W-1:0]  rounds_q;
  logic [fbc_pkg::RCNT_W-1:0]  rounds_w;
  logic [fbc_pkg::BLOCK_W-1:0] want_block;
  logic [fbc_pkg::BLOCK_W-1:0] expected_blocks[$];

  // Round key i: low half of the master key rotated right by 3*i mod 64
  function automatic logic [fbc_pkg::HALF_W-1:0] round_subkey(input int unsigned idx);
    logic [2*fbc_pkg::KEY_W-1:0] twice;
    twice = {key_q, key_q} >> ((3 * idx) % 64);
    return twice[fbc_pkg::HALF_W-1:0];
  endfunction

  // Round mix: rotl(L,9) xor not(xor of byte products of rotr(K,11) and L)
  function automatic logic [fbc_pkg::HALF_W-1:0] half_mix(
    input logic [fbc_pkg::HALF_W-1:0] l,
    input logic [fbc_pkg::HALF_W-1:0] k
  );
    logic [2*fbc_pkg::HALF_W-1:0] spin;
    logic [fbc_pkg::HALF_W-1:0]   kr;
    logic [fbc_pkg::HALF_W-1:0]   lr;
    logic [15:0]                  prod;
    spin = {k, k} >> 11;
    kr   = spin[fbc_pkg::HALF_W-1:0];
    spin = {l, l} >> (fbc_pkg::HALF_W - 9);
    lr   = spin[fbc_pkg::HALF_W-1:0];
    prod = '0;
    for (int a = 0; a < 4; a++) begin
      for (int b = 0; b < 4; b++) begin
        prod = prod ^ ({8'h00, kr[8*a +: 8]} * {8'h00, l[8*b +: 8]});
      end
    end
    return lr ^ ~{16'h0000, prod};
  endfunction

  // Run all rounds forward for encrypt, backward with reversed keys for decrypt
  function automatic logic [fbc_pkg::BLOCK_W-1:0] cipher_block(
    input logic                        decrypt,
    input logic [fbc_pkg::BLOCK_W-1:0] blk
  );
    logic [fbc_pkg::HALF_W-1:0] l;
    logic [fbc_pkg::HALF_W-1:0] r;
    logic [fbc_pkg::HALF_W-1:0] t;
    int unsigned                n;
    l = blk[fbc_pkg::BLOCK_W-1:fbc_pkg::HALF_W];
    r = blk[fbc_pkg::HALF_W-1:0];
    n = 32'(rounds_q);
    if (!decrypt) begin
      for (int unsigned i = 0; i < n; i++) begin
        t = r ^ half_mix(l, round_subkey(i));
        r = l;
        l = t;
      end
    end else begin
      for (int unsigned i = n; i > 0; i--) begin
        t = l ^ half_mix(r, round_subkey(i - 1));
        l = r;
        r = t;
      end
    end
    return {l, r};
  endfunction

  task automatic note_failure(input string what,
                              input logic [fbc_pkg::BLOCK_W-1:0] want,
                              input logic [fbc_pkg::BLOCK_W-1:0] got);
    if (fail_count_o < MAX_REPORTS) begin
      $display("%0t block_out %s: expected %h got %h", $realtime, what, want, got);
    end
    fail_count_o++;
  endtask

  // Follow register writes, queue predictions, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q           = '0;
      rounds_q        = fbc_pkg::RCNT_W'(fbc_pkg::MIN_ROUNDS);
      expected_blocks.delete();
      fail_count_o    = 0;
      pending_o       = 0;
      encrypt_count_o = 0;
      decrypt_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == fbc_pkg::CFG_CIPHER_KEY) begin
          key_q = cfg_wdata_i;
        end else if (cfg_index_i == fbc_pkg::CFG_ROUND_COUNT) begin
          // only the low six bits count, then clamp to the legal range
          rounds_w = cfg_wdata_i[fbc_pkg::RCNT_W-1:0];
          if (rounds_w > MAX_ROUNDS) rounds_w = fbc_pkg::RCNT_W'(MAX_ROUNDS);
          if (rounds_w < fbc_pkg::MIN_ROUNDS) begin
            rounds_w = fbc_pkg::RCNT_W'(fbc_pkg::MIN_ROUNDS);
          end
          rounds_q = rounds_w;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_blocks = {expected_blocks, cipher_block(operation_i, block_in_i)};
        if (operation_i) decrypt_count_o++;
        else encrypt_count_o++;
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_blocks.size() == 0) begin
          note_failure("with no request pending", '0, block_out_i);
        end else begin
          want_block = expected_blocks.pop_front();
          if (block_out_i !== want_block) begin
            note_failure("mismatch", want_block, block_out_i);
          end
        end
      end
      pending_o = unsigned'(expected_blocks.size());
    end
  end

endmodule

/* sim/feistel_block_cipher_tb.sv */
// ----------------------------------------------------------------------------
// Feistel block cipher testbench
// Drives directed and random encrypt/decrypt requests under a series of key
// and round-count settings, with random bursts of idle on both channels and
// one long output hold-off; the checker predicts and compares every block.
// ----------------------------------------------------------------------------
module feistel_block_cipher_tb;

  localparam int unsigned MAX_ROUNDS      = 32;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned ITEMS_PER_PHASE = 250;
  localparam int unsigned HOLD_CYCLES     = 200;
  localparam int unsigned DRAIN_CYCLES    = MAX_ROUNDS + 8;
  localparam int unsigned CYCLE_LIMIT     = 400000;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [fbc_pkg::CFG_IDX_W-1:0] cfg_index_i = fbc_pkg::CFG_CIPHER_KEY;
  logic [fbc_pkg::KEY_W-1:0]     cfg_wdata_i = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          operation_i = 1'b0;
  logic [fbc_pkg::BLOCK_W-1:0]   block_in_i  = '0;
  logic                          out_stall_i = 1'b0;
  logic                          in_stall_o;
  logic                          out_valid_o;
  logic [fbc_pkg::BLOCK_W-1:0]   block_out_o;

  int unsigned fail_count;
  int unsigned pending_blocks;
  int unsigned encrypt_count;
  int unsigned decrypt_count;
  int unsigned settings_count = 0;
  int unsigned cycle_count    = 0;
  bit          idle_on        = 1'b1;
  bit          hold_req       = 1'b0;

  feistel_block_cipher #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .block_in_i  (block_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .block_out_o (block_out_o)
  );

  fbc_block_checker #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .operation_i     (operation_i),
    .block_in_i      (block_in_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .block_out_i     (block_out_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending_blocks),
    .encrypt_count_o (encrypt_count),
    .decrypt_count_o (decrypt_count)
  );

  // Clock: period 8
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Output side: long hold-off on request, else random stall bursts
  always begin
    @(negedge clk_i);
    if (hold_req) begin
      hold_req    = 1'b0;
      out_stall_i = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk_i);
      out_stall_i = 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall_i = 1'b1;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
      out_stall_i = 1'b0;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  // Offer one request, with an optional idle burst first; hold until accepted
  task automatic send_block(input logic op, input logic [fbc_pkg::BLOCK_W-1:0] blk);
    int unsigned gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 17);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    operation_i = op;
    block_in_i  = blk;
    in_valid_i  = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and let every pending block drain out
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_blocks != 0) @(negedge clk_i);
    repeat (MAX_ROUNDS + 4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [fbc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fbc_pkg::KEY_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  task automatic apply_setting(input logic [fbc_pkg::KEY_W-1:0] key,
                               input logic [fbc_pkg::KEY_W-1:0] rounds);
    wait_idle();
    write_reg(fbc_pkg::CFG_CIPHER_KEY, key);
    write_reg(fbc_pkg::CFG_ROUND_COUNT, rounds);
    settings_count++;
  endtask

  // Mostly random blocks, with zero, all-ones and one-hot mixed in
  function automatic logic [fbc_pkg::BLOCK_W-1:0] pick_block();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    logic [fbc_pkg::KEY_W-1:0] key;
    logic [fbc_pkg::KEY_W-1:0] rounds;

    // Hold reset low, then release it
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: zero key, eight rounds
    send_block(1'b0, '0);
    send_block(1'b0, '1);
    send_block(1'b1, '0);
    send_block(1'b1, '1);

    // All-ones key at the round maximum
    apply_setting('1, 64'd32);
    send_block(1'b0, 64'h8000_0000_0000_0001);
    send_block(1'b1, 64'h0123_4567_89ab_cdef);

    // Round count above maximum saturates
    apply_setting(64'h8000_0000_0000_0001, 64'd63);
    send_block(1'b0, 64'h0000_0000_ffff_ffff);
    send_block(1'b1, 64'hffff_ffff_0000_0000);

    // Round count of zero and just below minimum clamp up to eight
    apply_setting(64'h0123_4567_89ab_cdef, 64'd0);
    send_block(1'b0, 64'hdead_beef_0bad_f00d);
    send_block(1'b1, 64'h0000_0001_8000_0000);
    apply_setting(64'hfedc_ba98_7654_3210, 64'd7);
    send_block(1'b0, 64'h5555_5555_aaaa_aaaa);
    send_block(1'b1, 64'haaaa_aaaa_5555_5555);

    // Upper write bits are dropped before the clamp
    apply_setting(64'h0f0f_0f0f_f0f0_f0f0, 64'hffff_ffff_ffff_ffd4);
    send_block(1'b0, 64'h0123_4567_89ab_cdef);
    send_block(1'b1, 64'h0123_4567_89ab_cdef);

    // Just inside both limits
    apply_setting(64'h1, 64'd9);
    send_block(1'b0, '1);
    send_block(1'b1, '0);
    apply_setting(64'h1 << 63, 64'd31);
    send_block(1'b0, '0);
    send_block(1'b1, '1);

    // Random phases, each under a fresh setting
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      if (p == 0) key = '0;
      else if (p == 1) key = '1;
      else key = {$urandom, $urandom};
      case (p % 4)
        0:       rounds = 64'd32;
        1:       rounds = 64'd8;
        2:       rounds = 64'($urandom_range(8, 32));
        default: rounds = {$urandom, $urandom};
      endcase
      apply_setting(key, rounds);
      if (p == NUM_PHASES - 1) idle_on = 1'b0;
      if (p == 2) hold_req = 1'b1;
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_block(1'($urandom_range(0, 1)), pick_block());
      end
    end

    // Drain
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_blocks != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d encrypt and %0d decrypt blocks under %0d key/round settings,",
             encrypt_count, decrypt_count, settings_count + 1);
    $display("with clamped round writes, a long output hold-off and a gap-free last phase.");
    if (fail_count == 0 && pending_blocks == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures, %0d blocks still pending", fail_count, pending_blocks);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/fbc_pkg.sv
design/fbc_round.sv
design/feistel_block_cipher.sv
sim/fbc_block_checker.sv
sim/feistel_block_cipher_tb.sv
